// ===== hdl/wpa_pkg.sv =====
// Package for the handshake pair tracker: word types and event codes.
// No dependencies.
package wpa_pkg;
   typedef struct packed {
      logic        req_type;
      logic [47:0] bssid;
      logic [47:0] src_addr;
      logic [47:0] dst_addr;
      logic [2:0]  msg_num;
      logic        nonce_present;
      logic        pmkid_present;
      logic        has_mic;
      logic        m2_in_bounds;
      logic [7:0]  radio_channel;
      logic signed [7:0] signal_level;
      logic [31:0] now_seconds;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [47:0] ap_addr;
      logic [47:0] station_addr;
      logic [7:0]  pair_channel;
      logic signed [7:0] pair_signal;
      logic [3:0]  seen_bitmap;
      logic        pmkid_flag;
      logic        usable;
      logic [1:0]  message_pair;
      logic        last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic [47:0] ap;
      logic [47:0] sta;
      logic [7:0]  chan;
      logic [7:0]  sig;
      logic [3:0]  bitmap;
      logic [4:0]  flags;
      logic [31:0] seen;
   } entry_type;

   localparam logic [1:0] EV_PMKID = 2'd0;
   localparam logic [1:0] EV_HS    = 2'd1;
   localparam logic [1:0] EV_DONE  = 2'd2;
   localparam logic       REQ_OBSERVE = 1'b0;
   localparam logic       REQ_TICK    = 1'b1;

   localparam int FL_PMKID = 0;
   localparam int FL_PMKID_SENT = 1;
   localparam int FL_HS_SENT = 2;
   localparam int FL_ANONCE = 3;
   localparam int FL_M2 = 4;
   localparam logic [15:0] DEFAULT_STALE = 16'd30;
endpackage

// ===== hdl/wpa_handshake_pair_tracker.sv =====
// Top level of the handshake pair tracker: table, sequencer, event output.
// Depends on wpa_pkg and wpa_match.
//
//  channel  dir  taken when               carries
//  req_     in   start & !busy at edge    one req_word_type word
//  rsp_     out  rsp_valid, one cycle     one rsp_word_type word, no backpressure
//  csr_     in   csr_wr_en at edge        stale_seconds
//
// Observe: a lookup walk over all MAX_PAIRS entries through the shared compare
// unit, an update state, then zero to two event words. Tick: a walk over all
// entries, then a flush state; a retire word is held until the next stale
// entry or the flush so its last flag is known. Each word is registered and
// shows in the cycle after its state; the last in the first idle cycle. Reset
// clears valid bits and count at once. No receiver stalls.
module wpa_handshake_pair_tracker
   import wpa_pkg::*;
#(
   parameter int MAX_PAIRS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   output logic         rsp_valid,
   output rsp_word_type rsp_word,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data
);
   localparam int IW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
   localparam int CW = $clog2(MAX_PAIRS + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FIND  = 3'd1;
   localparam logic [2:0] ST_UPD   = 3'd2;
   localparam logic [2:0] ST_EV1   = 3'd3;
   localparam logic [2:0] ST_EV2   = 3'd4;
   localparam logic [2:0] ST_TICK  = 3'd5;
   localparam logic [2:0] ST_FLUSH = 3'd6;

   logic [2:0]      state_ff, state_in;
   logic [IW-1:0]   idx_ff, idx_in;       // walk pointer
   logic [IW-1:0]   hit_ff, hit_in;       // matching entry
   logic            hit_ok_ff, hit_ok_in;
   logic [IW-1:0]   free_ff, free_in;     // lowest free entry
   logic            free_ok_ff, free_ok_in;
   logic            ev_hs_ff, ev_hs_in;   // handshake word follows
   logic            pend_v_ff, pend_v_in; // retire word held back
   rsp_word_type    pend_ff, pend_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_word_type    rsp_ff, rsp_in;
   logic [15:0]     stale_ff;
   logic [CW-1:0]   count_ff, count_in;
   logic [MAX_PAIRS-1:0] valid_ff, valid_in;
   entry_type       tab_ff [MAX_PAIRS];
   logic            tab_we;
   logic [IW-1:0]   tab_waddr;
   entry_type       tab_wdata;
   req_word_type    req_ff;
   logic [47:0]     key_sta;
   logic [47:0]     key_sta_ff;

   entry_type       cur;
   logic            key_hit, stale;
   logic [15:0]     limit;
   logic [IW-1:0]   sel, rd_idx;
   logic            last_idx;

   entry_type       upd;
   logic [2:0]      msg;
   logic            pm_ev, hs_ev;

   assign key_sta = (req_word.src_addr == req_word.bssid) ? req_word.dst_addr
                                                          : req_word.src_addr;
   assign limit = (stale_ff == 16'd0) ? DEFAULT_STALE : stale_ff;
   assign sel = hit_ok_ff ? hit_ff : free_ff;
   assign rd_idx = (state_ff == ST_FIND || state_ff == ST_TICK) ? idx_ff : sel;
   assign cur = tab_ff[rd_idx];

   wpa_match u_match (
      .entry  (cur),
      .key_ap (req_ff.bssid),
      .key_sta(key_sta_ff),
      .now    (req_ff.now_seconds),
      .limit  (limit),
      .key_hit(key_hit),
      .stale  (stale)
   );

   function automatic rsp_word_type make_ev(entry_type e, logic [1:0] kind,
                                            logic last);
      rsp_word_type r;
      r.event_kind = kind;
      r.ap_addr = e.ap;
      r.station_addr = e.sta;
      r.pair_channel = e.chan;
      r.pair_signal = e.sig;
      r.seen_bitmap = e.bitmap;
      r.pmkid_flag = e.flags[FL_PMKID];
      r.usable = 1'b0;
      r.message_pair = 2'd0;
      if (kind == EV_DONE) begin
         r.usable = e.flags[FL_PMKID] | (e.flags[FL_ANONCE] & e.flags[FL_M2]);
         r.message_pair = (e.bitmap[2] && !e.bitmap[0]) ? 2'd2 : 2'd0;
      end
      r.last_of_run = last;
      return r;
   endfunction

   assign last_idx = (idx_ff == IW'(MAX_PAIRS - 1));
   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;

   // updated entry contents for the update cycle
   always_comb begin
      msg = req_ff.msg_num;
      upd = cur;
      if (!hit_ok_ff) begin
         upd.ap = req_ff.bssid;
         upd.sta = key_sta_ff;
         upd.bitmap = 4'd0;
         upd.flags = 5'd0;
      end
      upd.chan = req_ff.radio_channel;
      upd.sig = req_ff.signal_level;
      upd.seen = req_ff.now_seconds;
      if (msg >= 3'd1 && msg <= 3'd4) upd.bitmap[msg[1:0] - 2'd1] = 1'b1;
      if ((msg == 3'd1 || msg == 3'd3) && req_ff.nonce_present) begin
         upd.flags[FL_ANONCE] = 1'b1;
      end
      pm_ev = (msg == 3'd1) && req_ff.pmkid_present && !upd.flags[FL_PMKID_SENT];
      if (pm_ev) begin
         upd.flags[FL_PMKID] = 1'b1;
         upd.flags[FL_PMKID_SENT] = 1'b1;
      end
      if (msg == 3'd2 && req_ff.has_mic && req_ff.m2_in_bounds) upd.flags[FL_M2] = 1'b1;
      hs_ev = (upd.bitmap[3:1] != 3'd0) && !upd.flags[FL_HS_SENT];
      if (hs_ev) upd.flags[FL_HS_SENT] = 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      hit_in = hit_ff;
      hit_ok_in = hit_ok_ff;
      free_in = free_ff;
      free_ok_in = free_ok_ff;
      ev_hs_in = ev_hs_ff;
      pend_v_in = pend_v_ff;
      pend_in = pend_ff;
      rsp_valid_in = 1'b0;
      rsp_in = rsp_ff;
      valid_in = valid_ff;
      count_in = count_ff;
      tab_we = 1'b0;
      tab_waddr = sel;
      tab_wdata = upd;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               idx_in = '0;
               hit_ok_in = 1'b0;
               free_ok_in = 1'b0;
               pend_v_in = 1'b0;
               state_in = (req_word.req_type == REQ_TICK) ? ST_TICK : ST_FIND;
            end
         end
         ST_FIND: begin
            if (valid_ff[idx_ff] && key_hit && !hit_ok_ff) begin
               hit_in = idx_ff;
               hit_ok_in = 1'b1;
            end
            if (!valid_ff[idx_ff] && !free_ok_ff) begin
               free_in = idx_ff;
               free_ok_in = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            if (last_idx) state_in = ST_UPD;
         end
         ST_UPD: begin
            ev_hs_in = hs_ev;
            if (hit_ok_ff || free_ok_ff) begin
               tab_we = 1'b1;
               if (!hit_ok_ff) begin
                  valid_in[sel] = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (pm_ev) state_in = ST_EV1;
               else if (hs_ev) state_in = ST_EV2;
               else state_in = ST_IDLE;
            end else begin
               // table full: word dropped
               state_in = ST_IDLE;
            end
         end
         ST_EV1: begin
            rsp_valid_in = 1'b1;
            rsp_in = make_ev(cur, EV_PMKID, !ev_hs_ff);
            state_in = ev_hs_ff ? ST_EV2 : ST_IDLE;
         end
         ST_EV2: begin
            rsp_valid_in = 1'b1;
            rsp_in = make_ev(cur, EV_HS, 1'b1);
            state_in = ST_IDLE;
         end
         ST_TICK: begin
            idx_in = idx_ff + 1'b1;
            if (valid_ff[idx_ff] && stale) begin
               // another retire follows, so the held one is not last
               if (pend_v_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = pend_ff;
               end
               pend_in = make_ev(cur, EV_DONE, 1'b0);
               pend_v_in = 1'b1;
               tab_we = 1'b1;
               tab_waddr = idx_ff;
               tab_wdata = '0;
               valid_in[idx_ff] = 1'b0;
               count_in = count_ff - 1'b1;
            end
            if (last_idx) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (pend_v_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in = pend_ff;
               rsp_in.last_of_run = 1'b1;
            end
            pend_v_in = 1'b0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         count_ff <= '0;
         stale_ff <= DEFAULT_STALE;
         rsp_valid_ff <= 1'b0;
         idx_ff <= '0;
         hit_ok_ff <= 1'b0;
         free_ok_ff <= 1'b0;
         ev_hs_ff <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         count_ff <= count_in;
         if (csr_wr_en) stale_ff <= csr_wr_data;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff <= idx_in;
         hit_ok_ff <= hit_ok_in;
         free_ok_ff <= free_ok_in;
         ev_hs_ff <= ev_hs_in;
         pend_v_ff <= pend_v_in;
      end
   end

   // datapath registers; contents only matter while flagged valid
   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      free_ff <= free_in;
      pend_ff <= pend_in;
      rsp_ff <= rsp_in;
      if (state_ff == ST_IDLE && start) begin
         req_ff <= req_word;
         key_sta_ff <= key_sta;
      end
      if (tab_we) tab_ff[tab_waddr] <= tab_wdata;
   end

   // sequencing checks for observe words; the count check holds always
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EV2) |-> $past(state_ff == ST_UPD || state_ff == ST_EV1))
      else $error("handshake event out of sequence");
   assert property (@(posedge clock) disable iff (reset)
      (count_ff == CW'($countones(valid_ff))))
      else $error("pair count disagrees with valid bits");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |-> $past(state_ff == ST_FIND))
      else $error("update without lookup");
endmodule

// ===== hdl/wpa_match.sv =====
// Shared compare unit: matches one entry against the key, or tests its age.
// Depends on wpa_pkg.
module wpa_match
   import wpa_pkg::*;
(
   input  entry_type   entry,
   input  logic [47:0] key_ap,
   input  logic [47:0] key_sta,
   input  logic [31:0] now,
   input  logic [15:0] limit,
   output logic        key_hit,
   output logic        stale
);
   logic [31:0] age;
   assign age = now - entry.seen;
   assign key_hit = (entry.ap == key_ap) && (entry.sta == key_sta);
   assign stale = age > {16'd0, limit};
endmodule

// ===== sim/wpa_handshake_pair_tracker_tb.sv =====
// Self-checking testbench for the handshake pair tracker.
// Depends on wpa_pkg and the wpa_handshake_pair_tracker RTL.
module wpa_handshake_pair_tracker_tb;
   import wpa_pkg::*;

   localparam int PAIRS = 16;
   localparam int CYCLE_LIMIT = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_valid;
   rsp_word_type rsp_word;
   logic         csr_wr_en = 1'b0;
   logic [15:0]  csr_wr_data = '0;

   wpa_handshake_pair_tracker #(.MAX_PAIRS(PAIRS)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Local copy of the pair table.
   logic        tbl_valid [PAIRS];
   entry_type   tbl [PAIRS];
   logic [15:0] stale_limit;

   rsp_word_type pending_events[$];
   int mismatches = 0;
   int cycles = 0;
   int predicted_n = 0;
   logic idle_enable = 1'b1;

   function automatic rsp_word_type make_event(logic [1:0] kind, int i);
      rsp_word_type r;
      r = '0;
      r.event_kind = kind;
      r.ap_addr = tbl[i].ap;
      r.station_addr = tbl[i].sta;
      r.pair_channel = tbl[i].chan;
      r.pair_signal = tbl[i].sig;
      r.seen_bitmap = tbl[i].bitmap;
      r.pmkid_flag = tbl[i].flags[FL_PMKID];
      if (kind == EV_DONE) begin
         r.usable = tbl[i].flags[FL_PMKID] |
                    (tbl[i].flags[FL_ANONCE] & tbl[i].flags[FL_M2]);
         r.message_pair = (tbl[i].bitmap[2] && !tbl[i].bitmap[0]) ? 2'd2 : 2'd0;
      end
      return r;
   endfunction

   // Applies one accepted word to the table and queues the events it causes.
   task automatic predict_events(input req_word_type w);
      rsp_word_type evs[$];
      logic [47:0] sta;
      logic [31:0] age, lim;
      int idx;
      idx = -1;
      if (w.req_type == REQ_TICK) begin
         lim = (stale_limit == 0) ? 32'd30 : {16'd0, stale_limit};
         for (int i = 0; i < PAIRS; i++) begin
            if (tbl_valid[i]) begin
               age = w.now_seconds - tbl[i].seen;
               if (age > lim) begin
                  evs.push_back(make_event(EV_DONE, i));
                  tbl_valid[i] = 1'b0;
                  tbl[i] = '0;
               end
            end
         end
      end else begin
         sta = (w.src_addr == w.bssid) ? w.dst_addr : w.src_addr;
         for (int i = 0; i < PAIRS && idx < 0; i++)
            if (tbl_valid[i] && tbl[i].ap == w.bssid && tbl[i].sta == sta) idx = i;
         if (idx < 0) begin
            for (int i = 0; i < PAIRS && idx < 0; i++)
               if (!tbl_valid[i]) idx = i;
            if (idx >= 0) begin
               tbl_valid[idx] = 1'b1;
               tbl[idx].ap = w.bssid;
               tbl[idx].sta = sta;
               tbl[idx].bitmap = '0;
               tbl[idx].flags = '0;
            end
         end
         if (idx >= 0) begin
            tbl[idx].chan = w.radio_channel;
            tbl[idx].sig = w.signal_level;
            tbl[idx].seen = w.now_seconds;
            if (w.msg_num >= 1 && w.msg_num <= 4)
               tbl[idx].bitmap[w.msg_num - 1] = 1'b1;
            if ((w.msg_num == 1 || w.msg_num == 3) && w.nonce_present)
               tbl[idx].flags[FL_ANONCE] = 1'b1;
            if (w.msg_num == 1 && w.pmkid_present && !tbl[idx].flags[FL_PMKID_SENT]) begin
               tbl[idx].flags[FL_PMKID] = 1'b1;
               tbl[idx].flags[FL_PMKID_SENT] = 1'b1;
               evs.push_back(make_event(EV_PMKID, idx));
            end
            if (w.msg_num == 2 && w.has_mic && w.m2_in_bounds)
               tbl[idx].flags[FL_M2] = 1'b1;
            if ((tbl[idx].bitmap & 4'hE) != 0 && !tbl[idx].flags[FL_HS_SENT]) begin
               tbl[idx].flags[FL_HS_SENT] = 1'b1;
               evs.push_back(make_event(EV_HS, idx));
            end
         end
      end
      if (evs.size() > 0) evs[evs.size() - 1].last_of_run = 1'b1;
      predicted_n = evs.size();
      foreach (evs[k]) pending_events.push_back(evs[k]);
   endtask

   task automatic report_mismatch(input string what, input rsp_word_type exp_w,
                                  input rsp_word_type act_w);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %h actual %h", what, exp_w, act_w);
   endtask

   // Result checker, field by field against the oldest expectation.
   always @(posedge clock) begin
      rsp_word_type e;
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (pending_events.size() == 0) begin
            report_mismatch("unexpected word", '0, rsp_word);
         end else begin
            e = pending_events.pop_front();
            if (rsp_word.event_kind !== e.event_kind ||
                rsp_word.ap_addr !== e.ap_addr ||
                rsp_word.station_addr !== e.station_addr ||
                rsp_word.pair_channel !== e.pair_channel ||
                rsp_word.pair_signal !== e.pair_signal ||
                rsp_word.seen_bitmap !== e.seen_bitmap ||
                rsp_word.pmkid_flag !== e.pmkid_flag ||
                rsp_word.usable !== e.usable ||
                rsp_word.message_pair !== e.message_pair ||
                rsp_word.last_of_run !== e.last_of_run)
               report_mismatch("field", e, rsp_word);
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("wpa_handshake_pair_tracker_tb: done, errors");
         $finish;
      end
   end

   // Optional pause; start drops only when a pause is taken.
   task automatic idle_gap();
      int n;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 18);
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Drives one word until accepted, then updates the prediction. start stays
   // high afterwards; the next word, a pause or drain() replaces or drops it.
   task automatic send_word(input req_word_type w);
      idle_gap();
      start <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_events(w);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (PAIRS + 8) @(posedge clock);
   endtask

   task automatic write_stale(input logic [15:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      stale_limit = v;
   endtask

   function automatic req_word_type random_req();
      logic [223:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return raw[$bits(req_word_type)-1:0];
   endfunction

   function automatic req_word_type observe_word(logic [47:0] ap, logic [47:0] sta,
                                                 logic [2:0] msg, logic [31:0] t);
      req_word_type w;
      w = '0;
      w.req_type = REQ_OBSERVE;
      w.bssid = ap;
      // half the time the frame comes from the AP
      if ($urandom_range(0, 1)) begin
         w.src_addr = ap; w.dst_addr = sta;
      end else begin
         w.src_addr = sta; w.dst_addr = ap;
      end
      w.msg_num = msg;
      w.nonce_present = 1'($urandom_range(0, 1));
      w.pmkid_present = 1'($urandom_range(0, 1));
      w.has_mic = 1'($urandom_range(0, 1));
      w.m2_in_bounds = 1'($urandom_range(0, 1));
      w.radio_channel = 8'($urandom_range(0, 255));
      w.signal_level = 8'($urandom_range(0, 255));
      w.now_seconds = t;
      return w;
   endfunction

   function automatic req_word_type tick_word(logic [31:0] t);
      req_word_type w;
      w = random_req();
      w.req_type = REQ_TICK;
      w.now_seconds = t;
      return w;
   endfunction

   // Directed table: expected results typed in where obvious (known_n >= 0 means
   // the word must give exactly that many results).
   typedef struct {
      req_word_type w;
      int known_n;
   } stim_row_type;

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      req_word_type w;
      logic [47:0] aps[4];
      logic [47:0] stas[8];
      logic [31:0] now;
      for (int i = 0; i < PAIRS; i++) begin
         tbl_valid[i] = 1'b0;
         tbl[i] = '0;
      end
      stale_limit = DEFAULT_STALE;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Tick on an empty table: nothing retires.
      row.w = tick_word(32'hFFFF_FFFF); row.known_n = 0; rows.push_back(row);
      // Extremes of addresses, all-ones fields, M1 with PMKID, then M3 without M1.
      w = '1; w.req_type = REQ_OBSERVE; w.msg_num = 3'd1; w.now_seconds = 32'd0;
      w.src_addr = 48'h0; row.w = w; row.known_n = 1; rows.push_back(row);
      w = '0; w.msg_num = 3'd3; w.nonce_present = 1'b1; w.src_addr = 48'h1;
      w.signal_level = -8'sd128; row.w = w; row.known_n = 1; rows.push_back(row);
      // Unknown message numbers.
      w.msg_num = 3'd0; row.w = w; row.known_n = 0; rows.push_back(row);
      w.msg_num = 3'd7; w.src_addr = 48'h2; row.w = w; row.known_n = 0; rows.push_back(row);
      w.msg_num = 3'd5; row.w = w; row.known_n = 0; rows.push_back(row);
      // M2 with MIC in bounds, M4, repeat PMKID (only once).
      w.msg_num = 3'd2; w.has_mic = 1'b1; w.m2_in_bounds = 1'b1; w.src_addr = 48'h3;
      row.w = w; row.known_n = 1; rows.push_back(row);
      w.msg_num = 3'd4; row.w = w; row.known_n = 0; rows.push_back(row);
      w.msg_num = 3'd1; w.pmkid_present = 1'b1; w.src_addr = 48'h4;
      row.w = w; row.known_n = 1; rows.push_back(row);
      row.known_n = 0; rows.push_back(row);
      // Tick just at the limit, then past it, then wrapped time.
      row.w = tick_word(32'd30); row.known_n = 0; rows.push_back(row);
      row.w = tick_word(32'd31); row.known_n = -1; rows.push_back(row);
      row.w = tick_word(32'h8000_0000); row.known_n = -1; rows.push_back(row);

      foreach (rows[r]) begin
         send_word(rows[r].w);
         if (rows[r].known_n >= 0 && predicted_n != rows[r].known_n) begin
            mismatches++;
            if (mismatches <= 10)
               $display("directed row %0d: expected %0d results, got %0d predicted",
                        r, rows[r].known_n, predicted_n);
         end
      end
      drain();

      // Fill the table past full: the seventeenth and eighteenth pairs are dropped.
      write_stale(16'd0);
      for (int i = 0; i < PAIRS + 2; i++)
         send_word(observe_word(48'hA0 + i, 48'hB0 + i, 3'd1, 32'd100));
      send_word(tick_word(32'd131));
      drain();

      // Random part over several register settings, small sets of pairs.
      for (int i = 0; i < 4; i++) aps[i] = 48'({$urandom, $urandom});
      for (int i = 0; i < 8; i++) stas[i] = 48'({$urandom, $urandom});
      now = $urandom;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_stale(16'd1);
            1: write_stale(16'hFFFF);
            2: write_stale(16'($urandom_range(2, 200)));
            default: write_stale(16'd0);
         endcase
         if (phase == 3) idle_enable = 1'b0;
         for (int k = 0; k < 18; k++) begin
            if ($urandom_range(0, 5) == 0) begin
               // jump time, possibly far enough to retire some pairs
               now = now + $urandom_range(0, (stale_limit == 0 ? 30 : stale_limit) * 2 + 2);
               send_word(tick_word(now));
            end else if ($urandom_range(0, 9) == 0) begin
               w = random_req();
               w.req_type = REQ_OBSERVE;
               now = now + $urandom_range(0, 3);
               w.now_seconds = now;
               send_word(w);
            end else begin
               now = now + $urandom_range(0, 3);
               send_word(observe_word(aps[$urandom_range(0, 3)], stas[$urandom_range(0, 7)],
                                      3'($urandom_range(1, 4)), now));
            end
         end
         send_word(tick_word(now + 32'h0001_0000));
         drain();
      end

      if (mismatches == 0 && pending_events.size() == 0) begin
         $display("wpa_handshake_pair_tracker_tb: done, clean");
      end else begin
         $display("wpa_handshake_pair_tracker_tb: done, errors");
      end
      $finish;
   end
endmodule
